// ===== sv/min_point_segment_distance_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the minimum point to segment distance block
// Shared property wrappers, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MIN_POINT_SEGMENT_DISTANCE_DEFINES_SVH
`define MIN_POINT_SEGMENT_DISTANCE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPSD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mpsd_pkg.sv =====
// ----------------------------------------------------------------------------
// mpsd_pkg
// Types, widths and the per-segment multiply sequence of the distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpsd_pkg;

    localparam int CW        = 32;              // coordinate width, Q16.16
    localparam int DW        = CW + 1;          // coordinate difference
    localparam int OPW       = 2 * DW + 1;      // signed multiplier operand
    localparam int MAGW      = OPW - 1;         // operand magnitude
    localparam int PW        = 2 * MAGW;        // product width
    localparam int NW        = PW + 2;          // sum of three products
    localparam int ACCW      = NW + 1;          // signed accumulator
    localparam int QW        = MAGW / 2;        // integer square root result
    localparam int OUTW      = 32;              // distance output width
    localparam int MUL_DIG   = 4;               // multiplier bits per cycle
    localparam int MPAD      = ((MAGW + MUL_DIG - 1) / MUL_DIG) * MUL_DIG;
    localparam int MUL_STEPS = MPAD / MUL_DIG;
    localparam int NUM_UOPS  = 24;
    localparam int UOP_W     = 5;

    localparam logic [QW-1:0] DIST_CAP = {1'b1, {OUTW{1'b0}}};

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [2:0]         seg_index;
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } t_req;

    typedef struct packed {
        logic [31:0] distance;
        logic        no_segments;
        logic        saturated;
    } t_rsp;

    typedef struct packed {
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] start_z;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
        logic signed [CW-1:0] end_z;
    } t_seg;

    typedef enum logic [3:0] {
        OP_D1X, OP_D1Y, OP_D1Z,
        OP_D2X, OP_D2Y, OP_D2Z,
        OP_EX,  OP_EY,  OP_EZ,
        OP_CX0, OP_CX1, OP_CX2
    } t_opsel;

    typedef enum logic [3:0] {
        DST_NONE, DST_DOT1, DST_DOT2, DST_DEN, DST_NA, DST_NB,
        DST_CX0, DST_CX1, DST_CX2, DST_NUM
    } t_dest;

    typedef struct packed {
        t_opsel a;
        t_opsel b;
        logic   first;   // clear the accumulator before this term
        logic   neg;     // subtract this term
        t_dest  dest;    // where the finished sum goes, none while summing
    } t_uop;

    typedef struct packed {
        logic seg_wr;
        logic pt_ld;
        logic rd;
        logic diff_ld;
        logic mul_start;
        logic root_start;
        logic best_init;
        logic best_upd;
        logic out_ld;
        logic out_empty;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic root_done;
        logic out_free;
    } t_sts;

    // Multiply sequence for one segment: two dot products, three squared
    // norms, the cross product and its squared norm.
    function automatic t_uop f_uop(input logic [UOP_W-1:0] step);
        t_uop u;
        unique case (step)
            5'd0:    u = '{OP_D1X, OP_EX,  1'b1, 1'b0, DST_NONE};
            5'd1:    u = '{OP_D1Y, OP_EY,  1'b0, 1'b0, DST_NONE};
            5'd2:    u = '{OP_D1Z, OP_EZ,  1'b0, 1'b0, DST_DOT1};
            5'd3:    u = '{OP_D2X, OP_EX,  1'b1, 1'b0, DST_NONE};
            5'd4:    u = '{OP_D2Y, OP_EY,  1'b0, 1'b0, DST_NONE};
            5'd5:    u = '{OP_D2Z, OP_EZ,  1'b0, 1'b0, DST_DOT2};
            5'd6:    u = '{OP_EX,  OP_EX,  1'b1, 1'b0, DST_NONE};
            5'd7:    u = '{OP_EY,  OP_EY,  1'b0, 1'b0, DST_NONE};
            5'd8:    u = '{OP_EZ,  OP_EZ,  1'b0, 1'b0, DST_DEN};
            5'd9:    u = '{OP_D1X, OP_D1X, 1'b1, 1'b0, DST_NONE};
            5'd10:   u = '{OP_D1Y, OP_D1Y, 1'b0, 1'b0, DST_NONE};
            5'd11:   u = '{OP_D1Z, OP_D1Z, 1'b0, 1'b0, DST_NA};
            5'd12:   u = '{OP_D2X, OP_D2X, 1'b1, 1'b0, DST_NONE};
            5'd13:   u = '{OP_D2Y, OP_D2Y, 1'b0, 1'b0, DST_NONE};
            5'd14:   u = '{OP_D2Z, OP_D2Z, 1'b0, 1'b0, DST_NB};
            5'd15:   u = '{OP_D1Y, OP_D2Z, 1'b1, 1'b0, DST_NONE};
            5'd16:   u = '{OP_D1Z, OP_D2Y, 1'b0, 1'b1, DST_CX0};
            5'd17:   u = '{OP_D1Z, OP_D2X, 1'b1, 1'b0, DST_NONE};
            5'd18:   u = '{OP_D1X, OP_D2Z, 1'b0, 1'b1, DST_CX1};
            5'd19:   u = '{OP_D1X, OP_D2Y, 1'b1, 1'b0, DST_NONE};
            5'd20:   u = '{OP_D1Y, OP_D2X, 1'b0, 1'b1, DST_CX2};
            5'd21:   u = '{OP_CX0, OP_CX0, 1'b1, 1'b0, DST_NONE};
            5'd22:   u = '{OP_CX1, OP_CX1, 1'b0, 1'b0, DST_NONE};
            5'd23:   u = '{OP_CX2, OP_CX2, 1'b0, 1'b0, DST_NUM};
            default: u = '{OP_D1X, OP_D1X, 1'b1, 1'b0, DST_NONE};
        endcase
        return u;
    endfunction

endpackage

// ===== sv/mpsd_mul.sv =====
// ----------------------------------------------------------------------------
// mpsd_mul
// Sequential unsigned multiplier, four multiplier bits retired per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpsd_mul (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [mpsd_pkg::MAGW-1:0] i_a,
    input  logic [mpsd_pkg::MAGW-1:0] i_b,
    output logic                     o_done,
    output logic [mpsd_pkg::PW-1:0]   o_prod
);

    localparam int MAGW  = mpsd_pkg::MAGW;
    localparam int DIG   = mpsd_pkg::MUL_DIG;
    localparam int MPAD  = mpsd_pkg::MPAD;
    localparam int HW    = MAGW + DIG;
    localparam int CNTW  = $clog2(mpsd_pkg::MUL_STEPS + 1);

    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [MAGW-1:0] r_mcand;
    logic [HW-1:0]   r_hi;
    logic [MPAD-1:0] r_lo;
    logic [HW-1:0]   w_pp;
    logic [HW-1:0]   w_sum;
    logic [HW+MPAD-1:0] w_full;

    // Partial product of the multiplicand and the current multiplier digit,
    // built from shifted copies of the multiplicand.
    always_comb begin
        w_pp = '0;
        for (int i = 0; i < DIG; i++) begin
            if (r_lo[i]) begin
                w_pp = w_pp + (HW'(r_mcand) << i);
            end
        end
    end

    // The high half stays below the multiplicand, so the sum never overflows.
    assign w_sum  = r_hi + w_pp;
    assign w_full = {r_hi, r_lo};
    assign o_prod = w_full[mpsd_pkg::PW-1:0];
    assign o_done = r_done;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNTW'(mpsd_pkg::MUL_STEPS);
        end else if (r_busy) begin
            n_cnt = r_cnt - CNTW'(1);
            if (r_cnt == CNTW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mcand <= i_a;
            r_hi    <= '0;
            r_lo    <= MPAD'(i_b);
        end else if (r_busy) begin
            r_hi <= {{DIG{1'b0}}, w_sum[HW-1:DIG]};
            r_lo <= {w_sum[DIG-1:0], r_lo[MPAD-1:DIG]};
        end
    end

endmodule

// ===== sv/mpsd_root.sv =====
// ----------------------------------------------------------------------------
// mpsd_root
// Floor of the square root of a ratio: restoring division, then a restoring
// square root, one bit or one digit pair per cycle. Result capped at 2^32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpsd_root (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [mpsd_pkg::NW-1:0] i_num,
    input  logic [mpsd_pkg::NW-1:0] i_den,
    output logic                    o_done,
    output logic [mpsd_pkg::QW-1:0] o_dist
);

    localparam int NW  = mpsd_pkg::NW;
    localparam int QW  = mpsd_pkg::QW;
    localparam int SW  = 2 * QW;
    localparam int RW  = QW + 2;
    localparam int RCW = $clog2(NW + 1);

    typedef enum logic [3:0] {
        RS_IDLE = 4'b0001,
        RS_DIV  = 4'b0010,
        RS_LOAD = 4'b0100,
        RS_SQRT = 4'b1000
    } t_rstate;

    t_rstate        r_state, n_state;
    logic [RCW-1:0] r_cnt, n_cnt;
    logic           r_done, n_done;
    logic [NW-1:0]  r_rem, r_quo, r_dvs;
    logic [SW-1:0]  r_x;
    logic [QW-1:0]  r_q;
    logic [RW-1:0]  r_srem;

    logic [NW:0]    w_dt, w_ddiff;
    logic           w_dge;
    logic [RW+1:0]  w_st, w_trial, w_sdiff;
    logic           w_sge;

    assign w_dt    = {r_rem, r_quo[NW-1]};
    assign w_ddiff = w_dt - {1'b0, r_dvs};
    assign w_dge   = (w_dt >= {1'b0, r_dvs});

    assign w_st    = {r_srem, r_x[SW-1:SW-2]};
    assign w_trial = {2'b00, r_q, 2'b01};
    assign w_sdiff = w_st - w_trial;
    assign w_sge   = (w_st >= w_trial);

    assign o_done = r_done;
    assign o_dist = (r_q > mpsd_pkg::DIST_CAP) ? mpsd_pkg::DIST_CAP : r_q;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        unique case (r_state)
            RS_IDLE: begin
                if (i_start) begin
                    n_state = RS_DIV;
                    n_cnt   = RCW'(NW);
                end
            end
            RS_DIV: begin
                n_cnt = r_cnt - RCW'(1);
                if (r_cnt == RCW'(1)) begin
                    n_state = RS_LOAD;
                end
            end
            RS_LOAD: begin
                n_state = RS_SQRT;
                n_cnt   = RCW'(QW);
            end
            RS_SQRT: begin
                n_cnt = r_cnt - RCW'(1);
                if (r_cnt == RCW'(1)) begin
                    n_state = RS_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: n_state = RS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= RS_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == RS_IDLE && i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_dvs <= i_den;
        end else if (r_state == RS_DIV) begin
            r_rem <= w_dge ? w_ddiff[NW-1:0] : w_dt[NW-1:0];
            r_quo <= {r_quo[NW-2:0], w_dge};
        end
    end

    // A quotient too large for the square root stage already lies far past
    // the cap, so it is clamped to all ones.
    always_ff @(posedge i_clk) begin
        if (r_state == RS_LOAD) begin
            r_x    <= (|r_quo[NW-1:SW]) ? {SW{1'b1}} : r_quo[SW-1:0];
            r_q    <= '0;
            r_srem <= '0;
        end else if (r_state == RS_SQRT) begin
            r_x    <= {r_x[SW-3:0], 2'b00};
            r_q    <= {r_q[QW-2:0], w_sge};
            r_srem <= w_sge ? w_sdiff[RW-1:0] : w_st[RW-1:0];
        end
    end

endmodule

// ===== sv/mpsd_datapath.sv =====
// ----------------------------------------------------------------------------
// mpsd_datapath
// Segment table, coordinate differences, multiply-accumulate, root unit,
// running minimum and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpsd_datapath #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mpsd_pkg::t_cmd                       i_cmd,
    input  mpsd_pkg::t_uop                       i_uop,
    input  logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] i_rd_addr,
    input  mpsd_pkg::t_req                       i_in_data,
    input  logic                                 i_out_stall,
    output mpsd_pkg::t_sts                       o_sts,
    output logic                                 o_out_valid,
    output mpsd_pkg::t_rsp                       o_out_data
);

    localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW   = mpsd_pkg::CW;
    localparam int DW   = mpsd_pkg::DW;
    localparam int OPW  = mpsd_pkg::OPW;
    localparam int MAGW = mpsd_pkg::MAGW;
    localparam int PW   = mpsd_pkg::PW;
    localparam int NW   = mpsd_pkg::NW;
    localparam int ACCW = mpsd_pkg::ACCW;
    localparam int QW   = mpsd_pkg::QW;
    localparam int OUTW = mpsd_pkg::OUTW;

    mpsd_pkg::t_seg r_mem [MAX_SEGMENTS];
    mpsd_pkg::t_seg r_rd;

    logic signed [CW-1:0]  r_px, r_py, r_pz;
    logic signed [DW-1:0]  r_d1 [3];
    logic signed [DW-1:0]  r_d2 [3];
    logic signed [DW-1:0]  r_e  [3];
    logic                  r_ez;
    logic signed [OPW-1:0] r_cx0, r_cx1, r_cx2;
    logic signed [ACCW-1:0] r_acc;
    logic                  r_dot1, r_dot2;
    logic [NW-1:0]         r_den, r_na, r_nb, r_num;
    logic [QW-1:0]         r_best;
    logic                  r_out_valid;
    mpsd_pkg::t_rsp        r_out;

    logic signed [OPW-1:0]  w_op_a, w_op_b;
    logic [MAGW-1:0]        w_mag_a, w_mag_b;
    logic                   w_mul_done;
    logic [PW-1:0]          w_prod;
    logic signed [ACCW-1:0] w_pext, w_term, w_sum;
    logic                   w_inside;
    logic [NW-1:0]          w_num, w_den;
    logic                   w_root_done;
    logic [QW-1:0]          w_root;

    function automatic logic signed [OPW-1:0] f_ext(input logic signed [DW-1:0] x);
        return {{(OPW-DW){x[DW-1]}}, x};
    endfunction

    function automatic logic signed [DW-1:0] f_diff(input logic signed [CW-1:0] a,
                                                    input logic signed [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic signed [OPW-1:0] f_op(input mpsd_pkg::t_opsel s);
        logic signed [OPW-1:0] v;
        unique case (s)
            mpsd_pkg::OP_D1X: v = f_ext(r_d1[0]);
            mpsd_pkg::OP_D1Y: v = f_ext(r_d1[1]);
            mpsd_pkg::OP_D1Z: v = f_ext(r_d1[2]);
            mpsd_pkg::OP_D2X: v = f_ext(r_d2[0]);
            mpsd_pkg::OP_D2Y: v = f_ext(r_d2[1]);
            mpsd_pkg::OP_D2Z: v = f_ext(r_d2[2]);
            mpsd_pkg::OP_EX:  v = f_ext(r_e[0]);
            mpsd_pkg::OP_EY:  v = f_ext(r_e[1]);
            mpsd_pkg::OP_EZ:  v = f_ext(r_e[2]);
            mpsd_pkg::OP_CX0: v = r_cx0;
            mpsd_pkg::OP_CX1: v = r_cx1;
            mpsd_pkg::OP_CX2: v = r_cx2;
            default:          v = '0;
        endcase
        return v;
    endfunction

    // Segment table.
    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_wr && ({29'd0, i_in_data.seg_index} < 32'(MAX_SEGMENTS))) begin
            r_mem[AW'(i_in_data.seg_index)] <= '{
                start_x: i_in_data.start_x, start_y: i_in_data.start_y,
                start_z: i_in_data.start_z, end_x: i_in_data.end_x,
                end_y: i_in_data.end_y, end_z: i_in_data.end_z};
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pt_ld) begin
            r_px <= i_in_data.point_x;
            r_py <= i_in_data.point_y;
            r_pz <= i_in_data.point_z;
        end
        if (i_cmd.diff_ld) begin
            r_d1[0] <= f_diff(r_rd.start_x, r_px);
            r_d1[1] <= f_diff(r_rd.start_y, r_py);
            r_d1[2] <= f_diff(r_rd.start_z, r_pz);
            r_d2[0] <= f_diff(r_rd.end_x, r_px);
            r_d2[1] <= f_diff(r_rd.end_y, r_py);
            r_d2[2] <= f_diff(r_rd.end_z, r_pz);
            r_e[0]  <= f_diff(r_rd.end_x, r_rd.start_x);
            r_e[1]  <= f_diff(r_rd.end_y, r_rd.start_y);
            r_e[2]  <= f_diff(r_rd.end_z, r_rd.start_z);
            r_ez    <= (r_rd.end_x == r_rd.start_x) && (r_rd.end_y == r_rd.start_y)
                       && (r_rd.end_z == r_rd.start_z);
        end
    end

    // Signed multiply-accumulate around the shared unsigned multiplier.
    assign w_op_a  = f_op(i_uop.a);
    assign w_op_b  = f_op(i_uop.b);
    assign w_mag_a = w_op_a[OPW-1] ? MAGW'(-w_op_a) : MAGW'(w_op_a);
    assign w_mag_b = w_op_b[OPW-1] ? MAGW'(-w_op_b) : MAGW'(w_op_b);

    mpsd_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_a     (w_mag_a),
        .i_b     (w_mag_b),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    assign w_pext = signed'({{(ACCW-PW){1'b0}}, w_prod});
    assign w_term = (i_uop.neg ^ w_op_a[OPW-1] ^ w_op_b[OPW-1]) ? -w_pext : w_pext;
    assign w_sum  = (i_uop.first ? '0 : r_acc) + w_term;

    always_ff @(posedge i_clk) begin
        if (w_mul_done) begin
            r_acc <= w_sum;
            unique case (i_uop.dest)
                mpsd_pkg::DST_NONE: ;
                mpsd_pkg::DST_DOT1: r_dot1 <= w_sum[ACCW-1] || (w_sum == '0);
                mpsd_pkg::DST_DOT2: r_dot2 <= !w_sum[ACCW-1];
                mpsd_pkg::DST_DEN:  r_den  <= w_sum[NW-1:0];
                mpsd_pkg::DST_NA:   r_na   <= w_sum[NW-1:0];
                mpsd_pkg::DST_NB:   r_nb   <= w_sum[NW-1:0];
                mpsd_pkg::DST_CX0:  r_cx0  <= w_sum[OPW-1:0];
                mpsd_pkg::DST_CX1:  r_cx1  <= w_sum[OPW-1:0];
                mpsd_pkg::DST_CX2:  r_cx2  <= w_sum[OPW-1:0];
                mpsd_pkg::DST_NUM:  r_num  <= w_sum[NW-1:0];
                default: ;
            endcase
        end
    end

    // Inside the segment the distance is the cross norm over the length,
    // otherwise the nearer endpoint; a zero-length segment takes the latter.
    assign w_inside = !r_ez && r_dot1 && r_dot2;
    assign w_num    = w_inside ? r_num : ((r_na < r_nb) ? r_na : r_nb);
    assign w_den    = w_inside ? r_den : NW'(1);

    mpsd_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.root_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_done  (w_root_done),
        .o_dist  (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_init) begin
            r_best <= mpsd_pkg::DIST_CAP;
        end else if (i_cmd.best_upd && (w_root < r_best)) begin
            r_best <= w_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            if (i_cmd.out_empty) begin
                r_out <= '{distance: '0, no_segments: 1'b1, saturated: 1'b0};
            end else if (r_best >= mpsd_pkg::DIST_CAP) begin
                r_out <= '{distance: '1, no_segments: 1'b0, saturated: 1'b1};
            end else begin
                r_out <= '{distance: r_best[OUTW-1:0], no_segments: 1'b0, saturated: 1'b0};
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out;
    assign o_sts.mul_done  = w_mul_done;
    assign o_sts.root_done = w_root_done;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

// ===== sv/mpsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpsd_ctrl
// Sequencer: takes requests, walks the segments and the multiply sequence,
// and hands results to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpsd_ctrl #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_req_type,
    output logic                o_in_stall,
    input  logic                i_cfg_valid,
    input  logic [3:0]          i_cfg_data,
    output logic                o_cfg_ready,
    input  mpsd_pkg::t_sts      i_sts,
    output mpsd_pkg::t_cmd      o_cmd,
    output mpsd_pkg::t_uop      o_uop,
    output logic [((MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1)-1:0] o_rd_addr
);

    localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int KW    = $clog2(MAX_SEGMENTS + 1);
    localparam int UOP_W = mpsd_pkg::UOP_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EMPTY = 9'b000000010,
        S_READ  = 9'b000000100,
        S_DIFF  = 9'b000001000,
        S_MUL   = 9'b000010000,
        S_MWAIT = 9'b000100000,
        S_ROOT  = 9'b001000000,
        S_RWAIT = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    t_state           r_state, n_state;
    logic [3:0]       r_count;
    logic [KW-1:0]    r_n, n_n;
    logic [KW-1:0]    r_k, n_k;
    logic [UOP_W-1:0] r_step, n_step;
    logic [KW-1:0]    w_n;
    logic             w_accept;

    assign w_n = ({28'd0, r_count} > 32'(MAX_SEGMENTS)) ? KW'(MAX_SEGMENTS)
                                                         : KW'(r_count);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_uop       = mpsd_pkg::f_uop(r_step);
    assign o_rd_addr   = r_k[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_k     = r_k;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == mpsd_pkg::REQ_WRITE) begin
                        o_cmd.seg_wr = 1'b1;
                    end else begin
                        o_cmd.pt_ld     = 1'b1;
                        o_cmd.best_init = 1'b1;
                        n_n = w_n;
                        n_k = '0;
                        n_state = (w_n == '0) ? S_EMPTY : S_READ;
                    end
                end
            end
            S_EMPTY: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld    = 1'b1;
                    o_cmd.out_empty = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_ld = 1'b1;
                n_step  = '0;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_start = 1'b1;
                n_state = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_sts.mul_done) begin
                    if (r_step == UOP_W'(mpsd_pkg::NUM_UOPS - 1)) begin
                        n_state = S_ROOT;
                    end else begin
                        n_step  = r_step + UOP_W'(1);
                        n_state = S_MUL;
                    end
                end
            end
            S_ROOT: begin
                o_cmd.root_start = 1'b1;
                n_state = S_RWAIT;
            end
            S_RWAIT: begin
                if (i_sts.root_done) begin
                    o_cmd.best_upd = 1'b1;
                    if ((r_k + KW'(1)) == r_n) begin
                        n_state = S_DONE;
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = S_READ;
                    end
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_ld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_n     <= '0;
            r_k     <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_n     <= n_n;
            r_k     <= n_k;
            r_step  <= n_step;
            if (i_cfg_valid) begin
                r_count <= i_cfg_data;
            end
        end
    end

endmodule

// ===== sv/min_point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// min_point_segment_distance
// Minimum Euclidean distance from a query point to a table of 3D segments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The block stores up to MAX_SEGMENTS segments in signed Q16.16 and answers
// point queries with the smallest distance to the first segment_count of
// them, as unsigned Q16.16 truncated toward zero and saturated at all ones.
// A write beat stores one segment and returns nothing. A query returns
// exactly one beat. With segment_count zero it returns no_segments.
// Otherwise the segments are worked through one after another by the
// single shared multiplier, which retires four bits of a 66-bit operand
// per cycle over 24 products per segment, and by the root unit, which
// runs a 134-step restoring division and a 33-step square root.
// Inputs are taken only while the block is idle; a finished result waits in
// the output register while the next request is already being worked on.
// segment_count is written on the configuration port, which is always ready.

`include "min_point_segment_distance_defines.svh"

module min_point_segment_distance #(
    parameter int MAX_SEGMENTS = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  mpsd_pkg::t_req i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output mpsd_pkg::t_rsp o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [3:0]     i_cfg_data
);

    localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

    mpsd_pkg::t_cmd w_cmd;
    mpsd_pkg::t_sts w_sts;
    mpsd_pkg::t_uop w_uop;
    logic [AW-1:0]  w_rd_addr;
    logic           w_wr_beat;

    // The sequencer owns the request state machine and the segment count register.
    mpsd_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_in_data.req_type),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_uop       (w_uop),
        .o_rd_addr   (w_rd_addr)
    );

    // The datapath holds the segment table, the arithmetic units and the
    // output register.
    mpsd_datapath #(
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_uop       (w_uop),
        .i_rd_addr   (w_rd_addr),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // A segment write beat taken at this edge.
    assign w_wr_beat = i_in_valid && !o_in_stall
                       && (i_in_data.req_type == mpsd_pkg::REQ_WRITE);

    // A result is only loaded when the output register can take it.
    `MPSD_ASSERT_SAME(a_out_ld_free, w_cmd.out_ld, (!o_out_valid || !i_out_stall), "output lost")
    // A segment write never produces a result beat.
    `MPSD_ASSERT_NEXT(a_wr_no_out, w_wr_beat, !w_cmd.out_ld, "write produced a result")
    // The root unit signals completion for a single cycle.
    `MPSD_ASSERT_NEXT(a_root_pulse, w_sts.root_done, !w_sts.root_done, "root done held")

endmodule
